FILE: sv/ciwm_pkg.sv
package ciwm_pkg;

   // Operation carried by each input word.
   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_TEXT   = 2'd2,
      OP_END    = 2'd3
   } op_type;

   // Pattern characters with a special meaning.
   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_ANY  = 8'h3F;

   // Bounds of the lower-case letters and their distance from upper case.
   localparam logic [7:0] LOWER_A     = 8'h61;
   localparam logic [7:0] LOWER_Z     = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // A word once decoded by the front end: the character is already case folded.
   typedef struct packed {
      op_type     op;
      logic [7:0] ch;
      logic       is_star;
      logic       is_any;
   } word_type;

   // Maps lower-case letters onto upper case and leaves every other byte alone.
   function automatic logic [7:0] fold_case(input logic [7:0] c);
      if (c >= LOWER_A && c <= LOWER_Z) begin
         return c - CASE_OFFSET;
      end
      return c;
   endfunction

endpackage

FILE: sv/ciwm_req_if.sv
interface ciwm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] ch;

   modport source (output valid, output op, output ch, input ready);
   modport sink (input valid, input op, input ch, output ready);
endinterface

FILE: sv/ciwm_rsp_if.sv
interface ciwm_rsp_if;
   logic valid;
   logic ready;
   logic matched;
   logic overflow;

   modport source (output valid, output matched, output overflow, input ready);
   modport sink (input valid, input matched, input overflow, output ready);
endinterface

FILE: sv/ciwm_front.sv
module ciwm_front
   import ciwm_pkg::*;
(
   ciwm_req_if.sink  req,
   output logic      push_valid,
   output word_type  push_word,
   input  logic      push_ready
);

   // Decode the incoming word: fold the character and flag the wildcards.
   always_comb begin
      push_word.op      = op_type'(req.op);
      push_word.ch      = fold_case(req.ch);
      push_word.is_star = (req.ch == CH_STAR);
      push_word.is_any  = (req.ch == CH_ANY);
   end

   assign push_valid = req.valid;
   assign req.ready  = push_ready;

endmodule

FILE: sv/ciwm_queue.sv
module ciwm_queue
   import ciwm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  word_type push_word,
   output logic     push_ready,
   output logic     pop_valid,
   output word_type pop_word,
   input  logic     pop_ready
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   word_type          entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_word   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count updates; the depth is a power of two so pointers wrap.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

FILE: sv/ciwm_engine.sv
module ciwm_engine
   import ciwm_pkg::*;
#(
   parameter int MAX_PATTERN = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       word_valid,
   input  word_type   word,
   output logic       word_ready,
   ciwm_rsp_if.source rsp
);

   localparam int W  = MAX_PATTERN + 1;
   localparam int LW = $clog2(W);

   logic [7:0]             pat_char_ff [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] any_ff;
   logic [MAX_PATTERN-1:0] star_ff;
   logic [MAX_PATTERN-1:0] star_in;
   logic [MAX_PATTERN-1:0] valid_ff;
   logic [MAX_PATTERN-1:0] valid_in;
   logic [MAX_PATTERN-1:0] hit_vec;
   logic [LW-1:0]          len_ff;
   logic [LW-1:0]          len_in;
   logic                   ovf_ff;
   logic                   ovf_in;
   logic [W-1:0]           act_ff;
   logic [W-1:0]           act_in;
   logic [W-1:0]           seed;
   logic [W-1:0]           step_vec;
   logic                   room;
   logic                   take;
   logic                   rsp_valid_ff;
   logic                   matched_ff;
   logic                   overflow_ff;

   // Sets every position reachable from the seed through runs of stars. The add
   // ripples a carry from each seeded star to the first non-star after its run.
   function automatic logic [W-1:0] star_closure(input logic [W-1:0] seed_v,
                                                 input logic [W-1:0] stars);
      logic [W-1:0] sum;
      sum = (seed_v & stars) + stars;
      return seed_v | (sum ^ stars);
   endfunction

   // An end-of-text word may only leave the queue when the result register is free or is being read.
   assign word_ready = (word.op != OP_END) || !rsp_valid_ff || rsp.ready;
   assign take       = word_valid && word_ready;
   assign room       = (len_ff != LW'(MAX_PATTERN));

   // Per-position character test against the folded text character.
   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         hit_vec[i] = valid_ff[i] & ~star_ff[i] & (any_ff[i] | (pat_char_ff[i] == word.ch));
      end
      step_vec = {1'b0, act_ff[MAX_PATTERN-1:0] & valid_ff & star_ff}
               | {act_ff[MAX_PATTERN-1:0] & hit_vec, 1'b0};
   end

   // Next pattern state and active set.
   always_comb begin
      star_in  = star_ff;
      valid_in = valid_ff;
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      seed     = W'(1);
      act_in   = act_ff;
      if (take) begin
         unique case (word.op)
            OP_CLEAR: begin
               star_in  = '0;
               valid_in = '0;
               len_in   = '0;
               ovf_in   = 1'b0;
            end
            OP_APPEND: begin
               if (room) begin
                  for (int i = 0; i < MAX_PATTERN; i++) begin
                     if (len_ff == LW'(i)) begin
                        star_in[i]  = word.is_star;
                        valid_in[i] = 1'b1;
                     end
                  end
                  len_in = len_ff + LW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            OP_TEXT: begin
               seed = step_vec;
            end
            OP_END: begin
               seed = W'(1);
            end
         endcase
         act_in = star_closure(seed, {1'b0, star_in});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         star_ff  <= '0;
         valid_ff <= '0;
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
         act_ff   <= W'(1);
      end else begin
         star_ff  <= star_in;
         valid_ff <= valid_in;
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
         act_ff   <= act_in;
      end
   end

   // Pattern characters are written once per append and need no reset.
   always_ff @(posedge clock) begin
      if (take && word.op == OP_APPEND && room) begin
         for (int i = 0; i < MAX_PATTERN; i++) begin
            if (len_ff == LW'(i)) begin
               pat_char_ff[i] <= word.ch;
               any_ff[i]      <= word.is_any;
            end
         end
      end
   end

   // Result register: holds its word until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && word.op == OP_END) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && word.op == OP_END) begin
         matched_ff  <= act_ff[len_ff] & ~ovf_ff;
         overflow_ff <= ovf_ff;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.matched  = matched_ff;
   assign rsp.overflow = overflow_ff;

endmodule

FILE: sv/case_insensitive_wildcard_match.sv
// Case-insensitive glob matcher with '*' and '?' wildcards.
// The req_if channel carries words of op and ch: clear pattern, append a
// pattern character, a text character, or end of text. The rsp_if channel
// returns one word per end of text with matched and overflow.
// A pattern holds up to MAX_PATTERN characters; further appends are dropped
// and raise overflow, which forces matched low until the next clear.
// One word is accepted per cycle, sustained while no end of text waits on a
// stalled result register. Each text character updates the set of active
// pattern positions; the star closure over that set is a single carry chain
// across MAX_PATTERN + 1 bits, which sets the clock. A result passes from its
// accepted end-of-text word through the two-entry queue between the decoder
// and the match engine, and then through the result register.
// When the receiver stalls, the result register holds its word; text and
// pattern words keep flowing, and a following end of text waits in the queue,
// so req_if.ready falls only once the queue has filled.
// Synchronous reset empties the pattern and the queue, clears overflow and
// drops any pending result.
module case_insensitive_wildcard_match
   import ciwm_pkg::*;
#(
   parameter int MAX_PATTERN = 32
) (
   input logic        clock,
   input logic        reset,
   ciwm_req_if.sink   req_if,
   ciwm_rsp_if.source rsp_if
);

   logic     push_valid;
   word_type push_word;
   logic     push_ready;
   logic     pop_valid;
   word_type pop_word;
   logic     pop_ready;

   // Decoder in front of the queue.
   ciwm_front u_front (
      .req        (req_if),
      .push_valid (push_valid),
      .push_word  (push_word),
      .push_ready (push_ready)
   );

   // Short queue that lets the decoder and the engine stall independently.
   ciwm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_word   (pop_word),
      .pop_ready  (pop_ready)
   );

   // Pattern store, active set and result register.
   ciwm_engine #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .word_valid (pop_valid),
      .word       (pop_word),
      .word_ready (pop_ready),
      .rsp        (rsp_if)
   );

endmodule

FILE: sv/ciwm_checker.sv
module ciwm_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_matched,
   input logic rsp_overflow
);

   // No result is pending straight after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present after reset");

   // An overflowed pattern never reports a match.
   a_overflow_no_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_matched && rsp_overflow))
      else $error("match reported together with overflow");

   // A stalled result word stays offered.
   a_valid_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word withdrawn while stalled");

   // A stalled result word keeps its payload.
   a_payload_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_matched) && $stable(rsp_overflow))
      else $error("result payload changed while stalled");

endmodule

bind case_insensitive_wildcard_match ciwm_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_matched  (rsp_if.matched),
   .rsp_overflow (rsp_if.overflow)
);
